// ===== rtl/mme_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mme_pkg;

	localparam int CMD_W   = 2;
	localparam int INDEX_W = 5;
	localparam int ELEM_W  = 16;
	localparam int PROD_W  = 2 * ELEM_W;
	localparam int VALUE_W = 37;
	localparam int CFG_W   = 6;

	localparam int MAX_DIM_DEFAULT = 32;

	localparam logic [CFG_W-1:0] INNER_LENGTH_RESET = 6'd1;

	localparam longint VALUE_MAX = (64'sd1 <<< (VALUE_W - 1)) - 64'sd1;
	localparam longint VALUE_MIN = -VALUE_MAX - 64'sd1;

	localparam logic [CMD_W-1:0] CMD_WR_LEFT  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WR_RIGHT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ     = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic clr;
		logic valid;
		logic last;
	} mac_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/mme_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface mme_cmd_if;
	logic                              valid;
	logic                              ready;
	logic [mme_pkg::CMD_W-1:0]         command;
	logic [mme_pkg::INDEX_W-1:0]       row_index;
	logic [mme_pkg::INDEX_W-1:0]       col_index;
	logic signed [mme_pkg::ELEM_W-1:0] element_value;

	modport source (
		output valid, command, row_index, col_index, element_value,
		input  ready
	);
	modport sink (
		input  valid, command, row_index, col_index, element_value,
		output ready
	);
endinterface

interface mme_res_if;
	logic                               valid;
	logic                               ready;
	logic [mme_pkg::INDEX_W-1:0]        product_row;
	logic [mme_pkg::INDEX_W-1:0]        product_col;
	logic signed [mme_pkg::VALUE_W-1:0] product_value;

	modport source (
		output valid, product_row, product_col, product_value,
		input  ready
	);
	modport sink (
		input  valid, product_row, product_col, product_value,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/matrix_multiply_engine.sv =====
// A write leaves the engine idle, so the next command can be taken in the cycle after its transfer.
// A read issues min(inner_length, MAX_DIM) store reads, drains the multiply-accumulate pipeline, loads its
// result and returns to idle, the only state in which a command is taken.
// A read with zero length or an out-of-range index goes straight to the output state and returns zero.
// A finished read waits to load its result while the previous result is still held.
// Reset clears the control state and sets inner_length to 1; the stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module matrix_multiply_engine #(
	parameter int MAX_DIM = mme_pkg::MAX_DIM_DEFAULT
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [mme_pkg::CFG_W-1:0] cfg_wdata,
	mme_cmd_if.sink                        cmd,
	mme_res_if.source                      res
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int LEN_W  = $clog2(MAX_DIM + 1);
	localparam int CMP_W  = mme_pkg::CFG_W + 1;

	mme_pkg::state_t state_q, state_d;

	logic [mme_pkg::CFG_W-1:0]   inner_len_q;
	logic [LEN_W-1:0]            len_q;
	logic [LEN_W-1:0]            k_q;
	logic [mme_pkg::INDEX_W-1:0] row_q;
	logic [mme_pkg::INDEX_W-1:0] col_q;

	logic                        cmd_rdy;
	logic                        rd_en;
	logic                        acc_clr;
	logic                        res_load;
	logic                        row_ok;
	logic                        col_ok;
	logic [CMP_W-1:0]            len_ext;
	logic [CMP_W-1:0]            len_sat;
	logic                        k_last;
	logic                        wr_left;
	logic                        wr_right;
	logic [ADDR_W-1:0]           wr_addr;
	logic [ADDR_W-1:0]           left_raddr;
	logic [ADDR_W-1:0]           right_raddr;
	logic                        rd_v_s1;
	logic                        last_s1;

	logic signed [mme_pkg::ELEM_W-1:0]  left_s1;
	logic signed [mme_pkg::ELEM_W-1:0]  right_s1;
	logic                               mac_done;
	logic signed [mme_pkg::VALUE_W-1:0] mac_result;
	mme_pkg::mac_ctrl_t                 mac_ctrl;

	logic                               res_valid_q;
	logic [mme_pkg::INDEX_W-1:0]        res_row_q;
	logic [mme_pkg::INDEX_W-1:0]        res_col_q;
	logic signed [mme_pkg::VALUE_W-1:0] res_value_q;

	assign row_ok  = CMP_W'(cmd.row_index) < CMP_W'(MAX_DIM);
	assign col_ok  = CMP_W'(cmd.col_index) < CMP_W'(MAX_DIM);
	assign len_ext = {1'b0, inner_len_q};
	assign len_sat = (len_ext > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM) : len_ext;
	assign k_last  = (k_q == len_q - LEN_W'(1));

	assign wr_left  = cmd.valid && cmd_rdy && (cmd.command == mme_pkg::CMD_WR_LEFT)
		&& row_ok && col_ok;
	assign wr_right = cmd.valid && cmd_rdy && (cmd.command == mme_pkg::CMD_WR_RIGHT)
		&& row_ok && col_ok;

	assign wr_addr     = ADDR_W'(cmd.row_index) * ADDR_W'(MAX_DIM) + ADDR_W'(cmd.col_index);
	assign left_raddr  = ADDR_W'(row_q) * ADDR_W'(MAX_DIM) + ADDR_W'(k_q);
	assign right_raddr = ADDR_W'(k_q) * ADDR_W'(MAX_DIM) + ADDR_W'(col_q);

	always_comb begin
		state_d  = state_q;
		cmd_rdy  = 1'b0;
		rd_en    = 1'b0;
		acc_clr  = 1'b0;
		res_load = 1'b0;
		unique case (state_q)
			mme_pkg::ST_IDLE: begin
				cmd_rdy = 1'b1;
				if (cmd.valid && (cmd.command == mme_pkg::CMD_READ)) begin
					acc_clr = 1'b1;
					if (row_ok && col_ok && (len_sat != '0)) begin
						state_d = mme_pkg::ST_ISSUE;
					end else begin
						state_d = mme_pkg::ST_OUT;
					end
				end
			end
			mme_pkg::ST_ISSUE: begin
				rd_en = 1'b1;
				if (k_last) begin
					state_d = mme_pkg::ST_DRAIN;
				end
			end
			mme_pkg::ST_DRAIN: begin
				if (mac_done) begin
					state_d = mme_pkg::ST_OUT;
				end
			end
			mme_pkg::ST_OUT: begin
				if (!res_valid_q || res.ready) begin
					res_load = 1'b1;
					state_d  = mme_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mme_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mme_pkg::ST_IDLE;
			inner_len_q <= mme_pkg::INNER_LENGTH_RESET;
			k_q         <= '0;
			rd_v_s1     <= 1'b0;
			last_s1     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				inner_len_q <= cfg_wdata;
			end
			if (acc_clr) begin
				k_q <= '0;
			end else if (rd_en) begin
				k_q <= k_q + LEN_W'(1);
			end
			rd_v_s1 <= rd_en;
			last_s1 <= rd_en && k_last;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_clr) begin
			row_q <= cmd.row_index;
			col_q <= cmd.col_index;
			len_q <= LEN_W'(len_sat);
		end
		if (res_load) begin
			res_row_q   <= row_q;
			res_col_q   <= col_q;
			res_value_q <= mac_result;
		end
	end

	mme_store #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_left_store (
		.clk   (clk),
		.we    (wr_left),
		.waddr (wr_addr),
		.wdata (cmd.element_value),
		.re    (rd_en),
		.raddr (left_raddr),
		.rdata (left_s1)
	);

	mme_store #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_right_store (
		.clk   (clk),
		.we    (wr_right),
		.waddr (wr_addr),
		.wdata (cmd.element_value),
		.re    (rd_en),
		.raddr (right_raddr),
		.rdata (right_s1)
	);

	assign mac_ctrl = '{clr: acc_clr, valid: rd_v_s1, last: last_s1};

	mme_mac #(
		.MAX_DIM (MAX_DIM)
	) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (mac_ctrl),
		.left_s1  (left_s1),
		.right_s1 (right_s1),
		.done     (mac_done),
		.result   (mac_result)
	);

	assign cmd.ready         = cmd_rdy;
	assign res.valid         = res_valid_q;
	assign res.product_row   = res_row_q;
	assign res.product_col   = res_col_q;
	assign res.product_value = res_value_q;

	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> (state_q == mme_pkg::ST_DRAIN))
		else $error("accumulator finished outside the drain state");

	a_no_write_during_read: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_left || wr_right) |-> (!rd_en && !rd_v_s1 && !mac_ctrl.valid))
		else $error("store write overlaps a product read");

	a_index_in_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mme_pkg::ST_ISSUE) |-> (k_q < len_q))
		else $error("inner index ran past the configured length");

endmodule

`default_nettype wire

// ===== rtl/mme_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mme_store #(
	parameter int DEPTH  = mme_pkg::MAX_DIM_DEFAULT * mme_pkg::MAX_DIM_DEFAULT,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic                              clk,
	input  wire logic                              we,
	input  wire logic [ADDR_W-1:0]                 waddr,
	input  wire logic signed [mme_pkg::ELEM_W-1:0] wdata,
	input  wire logic                              re,
	input  wire logic [ADDR_W-1:0]                 raddr,
	output      logic signed [mme_pkg::ELEM_W-1:0] rdata
);

	logic signed [mme_pkg::ELEM_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/mme_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mme_mac #(
	parameter int MAX_DIM = mme_pkg::MAX_DIM_DEFAULT
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire mme_pkg::mac_ctrl_t                 ctrl,
	input  wire logic signed [mme_pkg::ELEM_W-1:0]  left_s1,
	input  wire logic signed [mme_pkg::ELEM_W-1:0]  right_s1,
	output      logic                               done,
	output      logic signed [mme_pkg::VALUE_W-1:0] result
);

	localparam int SUM_W = mme_pkg::PROD_W + 1 + $clog2(MAX_DIM);
	localparam int ACC_W = (SUM_W > mme_pkg::VALUE_W) ? SUM_W : mme_pkg::VALUE_W;
	localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(mme_pkg::VALUE_MAX);
	localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(mme_pkg::VALUE_MIN);

	logic signed [mme_pkg::PROD_W-1:0] prod_s2;
	logic                              valid_s2;
	logic                              last_s2;
	logic signed [ACC_W-1:0]           acc_q;
	logic                              done_q;
	logic signed [ACC_W-1:0]           sat;

	always_ff @(posedge clk) begin
		if (ctrl.valid) begin
			prod_s2 <= left_s1 * right_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			last_s2  <= 1'b0;
			acc_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			valid_s2 <= ctrl.valid;
			last_s2  <= ctrl.valid && ctrl.last;
			if (ctrl.clr) begin
				acc_q  <= '0;
				done_q <= 1'b0;
			end else begin
				if (valid_s2) begin
					acc_q <= acc_q + ACC_W'(prod_s2);
				end
				done_q <= valid_s2 && last_s2;
			end
		end
	end

	always_comb begin
		if (acc_q > SAT_MAX) begin
			sat = SAT_MAX;
		end else if (acc_q < SAT_MIN) begin
			sat = SAT_MIN;
		end else begin
			sat = acc_q;
		end
	end

	assign result = mme_pkg::VALUE_W'(sat);
	assign done   = done_q;

endmodule

`default_nettype wire

// ===== bench/matrix_multiply_engine_tb.sv =====
`timescale 1ns / 1ps

module matrix_multiply_engine_tb;

	localparam int DIM            = mme_pkg::MAX_DIM_DEFAULT;
	localparam int DRAIN_CYCLES   = 48;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int MAX_REPORTS    = 50;

	localparam logic [mme_pkg::CMD_W-1:0]         CMD_UNUSED = 2'd3;
	localparam logic signed [mme_pkg::ELEM_W-1:0] ELEM_MIN   = 16'sh8000;
	localparam logic signed [mme_pkg::ELEM_W-1:0] ELEM_MAX   = 16'sh7fff;
	localparam logic [mme_pkg::CFG_W-1:0]         LEN_FULL   = 6'd32;
	localparam logic [mme_pkg::CFG_W-1:0]         LEN_TOP    = 6'd63;

	typedef struct {
		logic [mme_pkg::INDEX_W-1:0]        row;
		logic [mme_pkg::INDEX_W-1:0]        col;
		logic signed [mme_pkg::VALUE_W-1:0] value;
	} product_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [mme_pkg::CFG_W-1:0] cfg_wdata;

	mme_cmd_if cmd_ch();
	mme_res_if res_ch();

	matrix_multiply_engine u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_ch),
		.res       (res_ch)
	);

	// Model of the block's state, updated on every command transfer and configuration write.
	logic signed [mme_pkg::ELEM_W-1:0] left_store  [DIM*DIM];
	logic signed [mme_pkg::ELEM_W-1:0] right_store [DIM*DIM];
	logic [mme_pkg::CFG_W-1:0]         inner_len_model = mme_pkg::INNER_LENGTH_RESET;
	product_t                          pending_products [$];
	product_t                          next_product;

	// Stimulus side bookkeeping, so that no read touches an unwritten entry.
	bit left_written  [DIM][DIM];
	bit right_written [DIM][DIM];
	int gen_len = 1;
	int items_sent;
	int last_row;
	int last_col;

	int send_idle_pct;
	int recv_stall_pct;
	int hold_trigger;
	int hold_seen;
	int hold_left;
	int quiet_cycles;
	int error_count;

	always #5 clk = ~clk;

	task automatic report_error(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	function automatic logic signed [mme_pkg::VALUE_W-1:0] dot_product(input int row,
			input int col);
		longint acc;
		int     terms;
		acc   = 0;
		terms = (inner_len_model > DIM) ? DIM : int'(inner_len_model);
		if (row < DIM && col < DIM) begin
			for (int k = 0; k < terms; k++)
				acc += longint'(left_store[row*DIM + k]) * longint'(right_store[k*DIM + col]);
		end
		if (acc > mme_pkg::VALUE_MAX)
			acc = mme_pkg::VALUE_MAX;
		if (acc < mme_pkg::VALUE_MIN)
			acc = mme_pkg::VALUE_MIN;
		return acc[mme_pkg::VALUE_W-1:0];
	endfunction

	always @(posedge clk) begin
		if (cfg_we)
			inner_len_model = cfg_wdata;
		if (cmd_ch.valid && cmd_ch.ready) begin
			case (cmd_ch.command)
				mme_pkg::CMD_WR_LEFT: begin
					if (cmd_ch.row_index < DIM && cmd_ch.col_index < DIM)
						left_store[int'(cmd_ch.row_index)*DIM + int'(cmd_ch.col_index)] =
							cmd_ch.element_value;
				end
				mme_pkg::CMD_WR_RIGHT: begin
					if (cmd_ch.row_index < DIM && cmd_ch.col_index < DIM)
						right_store[int'(cmd_ch.row_index)*DIM + int'(cmd_ch.col_index)] =
							cmd_ch.element_value;
				end
				mme_pkg::CMD_READ: begin
					pending_products.push_back('{cmd_ch.row_index, cmd_ch.col_index,
						dot_product(int'(cmd_ch.row_index), int'(cmd_ch.col_index))});
				end
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		if (res_ch.valid && res_ch.ready) begin
			if (pending_products.size() == 0) begin
				report_error($sformatf("unexpected product row %0d col %0d value %0d",
					res_ch.product_row, res_ch.product_col, res_ch.product_value));
			end else begin
				next_product = pending_products.pop_front();
				if (res_ch.product_row !== next_product.row)
					report_error($sformatf("product_row %0d, expected %0d",
						res_ch.product_row, next_product.row));
				if (res_ch.product_col !== next_product.col)
					report_error($sformatf("product_col %0d, expected %0d",
						res_ch.product_col, next_product.col));
				if (res_ch.product_value !== next_product.value)
					report_error($sformatf("product_value %0d at (%0d,%0d), expected %0d",
						res_ch.product_value, next_product.row, next_product.col,
						next_product.value));
			end
		end
	end

	// Result ready: long hold-off per trigger while commands flow, else random stalls.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			res_ch.ready <= 1'b0;
			hold_left--;
		end else if (hold_trigger != hold_seen) begin
			hold_seen = hold_trigger;
			hold_left = HOLD_CYCLES - 1;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin : watchdog
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("[%0t] no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	task automatic send_item(input logic [mme_pkg::CMD_W-1:0] op, input int row, input int col,
			input logic [mme_pkg::ELEM_W-1:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid         <= 1'b1;
		cmd_ch.command       <= op;
		cmd_ch.row_index     <= row[mme_pkg::INDEX_W-1:0];
		cmd_ch.col_index     <= col[mme_pkg::INDEX_W-1:0];
		cmd_ch.element_value <= value;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		if (op == mme_pkg::CMD_WR_LEFT && row < DIM && col < DIM)
			left_written[row][col] = 1'b1;
		if (op == mme_pkg::CMD_WR_RIGHT && row < DIM && col < DIM)
			right_written[row][col] = 1'b1;
		items_sent++;
	endtask

	task automatic wait_quiet();
		cmd_ch.valid <= 1'b0;
		while (pending_products.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_inner_length(input logic [mme_pkg::CFG_W-1:0] len);
		wait_quiet();
		cfg_we    <= 1'b1;
		cfg_wdata <= len;
		@(posedge clk);
		cfg_we  <= 1'b0;
		gen_len = (len > DIM) ? DIM : int'(len);
	endtask

	function automatic bit can_read(input int row, input int col);
		for (int k = 0; k < gen_len; k++)
			if (!left_written[row][k] || !right_written[k][col])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [mme_pkg::ELEM_W-1:0] pick_element();
		int sel;
		sel = $urandom_range(99);
		if (sel < 15)
			return ELEM_MIN;
		if (sel < 30)
			return ELEM_MAX;
		if (sel < 40)
			return '0;
		return mme_pkg::ELEM_W'($urandom);
	endfunction

	task automatic send_noise();
		int sel;
		sel = $urandom_range(3);
		case (sel)
			0: send_item(mme_pkg::CMD_WR_LEFT, $urandom_range(DIM-1), $urandom_range(DIM-1),
				pick_element());
			1: send_item(mme_pkg::CMD_WR_RIGHT, $urandom_range(DIM-1), $urandom_range(DIM-1),
				pick_element());
			2: begin
				if (can_read(last_row, last_col))
					send_item(mme_pkg::CMD_READ, last_row, last_col,
						mme_pkg::ELEM_W'($urandom));
				else
					send_item(CMD_UNUSED, $urandom_range(DIM-1), $urandom_range(DIM-1),
						mme_pkg::ELEM_W'($urandom));
			end
			default: send_item(CMD_UNUSED, $urandom_range(DIM-1), $urandom_range(DIM-1),
				mme_pkg::ELEM_W'($urandom));
		endcase
	endtask

	// Each sequence fills unwritten entries of one left row and right column, then reads.
	task automatic run_sequences(input int count);
		int first;
		int row;
		int col;
		first = items_sent;
		while (items_sent - first < count) begin
			row = $urandom_range(DIM-1);
			col = $urandom_range(DIM-1);
			for (int k = 0; k < gen_len; k++) begin
				if (!left_written[row][k] || $urandom_range(3) == 0)
					send_item(mme_pkg::CMD_WR_LEFT, row, k, pick_element());
				if (!right_written[k][col] || $urandom_range(3) == 0)
					send_item(mme_pkg::CMD_WR_RIGHT, k, col, pick_element());
			end
			send_item(mme_pkg::CMD_READ, row, col, mme_pkg::ELEM_W'($urandom));
			last_row = row;
			last_col = col;
			while ($urandom_range(2) == 0)
				send_noise();
		end
	endtask

	task automatic test_directed();
		send_item(mme_pkg::CMD_WR_LEFT, 0, 0, ELEM_MIN);
		send_item(mme_pkg::CMD_WR_RIGHT, 0, 0, ELEM_MIN);
		send_item(mme_pkg::CMD_READ, 0, 0, '0);
		send_item(mme_pkg::CMD_WR_LEFT, DIM-1, 0, ELEM_MAX);
		send_item(mme_pkg::CMD_WR_RIGHT, 0, DIM-1, ELEM_MAX);
		send_item(mme_pkg::CMD_READ, DIM-1, DIM-1, '1);
		send_item(mme_pkg::CMD_READ, 0, DIM-1, '0);
		send_item(mme_pkg::CMD_READ, DIM-1, 0, '0);
		send_item(CMD_UNUSED, DIM-1, DIM-1, '1);
		send_item(CMD_UNUSED, 0, 0, '0);
		send_item(mme_pkg::CMD_WR_LEFT, 5, 0, '0);
		send_item(mme_pkg::CMD_WR_RIGHT, 0, 5, 16'sh0001);
		send_item(mme_pkg::CMD_READ, 5, 5, '0);
		set_inner_length('0);
		send_item(mme_pkg::CMD_READ, DIM-1, DIM-1, '0);
		send_item(mme_pkg::CMD_READ, 17, 9, '1);
		send_item(mme_pkg::CMD_READ, 0, 0, '0);
	endtask

	task automatic test_full_length();
		set_inner_length(LEN_FULL);
		for (int k = 0; k < DIM; k++) begin
			send_item(mme_pkg::CMD_WR_LEFT, 0, k, ELEM_MIN);
			send_item(mme_pkg::CMD_WR_RIGHT, k, 0, ELEM_MIN);
		end
		send_item(mme_pkg::CMD_READ, 0, 0, '0);
		for (int k = 0; k < DIM; k++)
			send_item(mme_pkg::CMD_WR_RIGHT, k, 1, ELEM_MAX);
		send_item(mme_pkg::CMD_READ, 0, 1, '0);
		set_inner_length(LEN_TOP);
		send_item(mme_pkg::CMD_READ, 0, 0, '0);
		send_item(mme_pkg::CMD_READ, 0, 1, '0);
	endtask

	task automatic test_traffic(input int idle_pct, input int stall_pct, input int count);
		wait_quiet();
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		set_inner_length($urandom_range(1) ? LEN_FULL : LEN_TOP);
		run_sequences(count / 4);
		set_inner_length(mme_pkg::CFG_W'($urandom_range(2, 12)));
		run_sequences(count / 4);
		set_inner_length(6'd1);
		run_sequences(count / 4);
		set_inner_length('0);
		run_sequences(count / 4);
	endtask

	task automatic test_backpressure();
		wait_quiet();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		set_inner_length(6'd3);
		for (int k = 0; k < 3; k++) begin
			send_item(mme_pkg::CMD_WR_LEFT, 7, k, pick_element());
			send_item(mme_pkg::CMD_WR_RIGHT, k, 9, pick_element());
		end
		wait_quiet();
		hold_trigger++;
		for (int i = 0; i < 24; i++)
			send_item(mme_pkg::CMD_READ, 7, 9, mme_pkg::ELEM_W'($urandom));
	endtask

	initial begin
		clk                  = 1'b0;
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_wdata            = '0;
		cmd_ch.valid         = 1'b0;
		cmd_ch.command       = CMD_UNUSED;
		cmd_ch.row_index     = '0;
		cmd_ch.col_index     = '0;
		cmd_ch.element_value = '0;
		res_ch.ready         = 1'b0;
		send_idle_pct        = 0;
		recv_stall_pct       = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_length();
		test_traffic(0, 0, 200);
		test_traffic(70, 0, 200);
		test_traffic(0, 70, 200);
		test_traffic(29, 29, 200);
		test_backpressure();

		wait_quiet();
		if (pending_products.size() != 0)
			report_error($sformatf("%0d products never arrived", pending_products.size()));
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
